[design/cbe_pkg.sv]
// cbe_pkg: shared widths, register map, reset values and interface structs
// for the cubic bezier easing block
// no dependencies
`default_nettype none

package cbe_pkg;

   // fixed-point formats
   localparam int FRAC_BITS = 16;
   localparam int TIME_W    = 17;              // time_in, unsigned
   localparam int VAL_W     = 19;              // value, signed
   localparam int CX_W      = 17;              // control x, unsigned
   localparam int CY_W      = 19;              // control y, signed
   localparam int STEPS_W   = 5;               // bisect_steps
   localparam int T_W       = 32;              // curve parameter t, Q32
   localparam int TM_W      = TIME_W + 1;      // signed (possibly mirrored) time
   localparam int MUL_W     = T_W + 2;         // signed multiplier operand width
   localparam int PROD_W    = T_W + CY_W + 1;  // coefficient times control point
   localparam int ACC_W     = PROD_W + 2;      // sum of three terms plus rounding
   localparam int V_W       = ACC_W - T_W;     // rounded value before mirror
   localparam int MAX_STEPS_DEF = 24;

   // stream payload widths, whole bytes
   localparam int REQ_DATA_W = ((TIME_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VAL_W + 7) / 8) * 8;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_CTRL1_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL1_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL2_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL2_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BISECT_STEPS = 3'd5;

   localparam logic        [CX_W-1:0]    CTRL1_X_RST      = 17'd19661;
   localparam logic signed [CY_W-1:0]    CTRL1_Y_RST      = 19'sd19661;
   localparam logic        [CX_W-1:0]    CTRL2_X_RST      = 17'd45875;
   localparam logic signed [CY_W-1:0]    CTRL2_Y_RST      = 19'sd45875;
   localparam logic                      REVERSE_RST      = 1'b0;
   localparam logic        [STEPS_W-1:0] BISECT_STEPS_RST = 5'd20;

   // output saturation bounds
   localparam logic signed [V_W:0] OUT_MIN = -(V_W+1)'(131072);
   localparam logic signed [V_W:0] OUT_MAX = (V_W+1)'(196608);

   typedef struct packed {
      logic [CX_W-1:0]    ctrl1_x;
      logic [CY_W-1:0]    ctrl1_y;
      logic [CX_W-1:0]    ctrl2_x;
      logic [CY_W-1:0]    ctrl2_y;
      logic               reverse;
      logic [STEPS_W-1:0] bisect_steps;
   } cbe_cfg_type;

   typedef struct packed {
      logic start;      // load a new transaction
      logic start_nz;   // at least one bisection step
      logic ypass;      // coefficients are the y control points
      logic mul1;       // u*t and t*t
      logic mul2;       // bernstein weights
      logic mul3;       // weights times control points
      logic cmp;        // compare x(t) with the time, move t
      logic last;       // final bisection step, t stays
      logic ysum;       // register y(t) sum
      logic out_load;   // load the result register
   } cbe_cmd_type;

endpackage

`default_nettype wire

[design/cbe_csr.sv]
// cbe_csr: configuration register file behind the apb-style port
// depends on cbe_pkg
`default_nettype none

module cbe_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [cbe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [cbe_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [cbe_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output cbe_pkg::cbe_cfg_type                 cfg
);
   import cbe_pkg::*;

   cbe_cfg_type            cfg_ff, cfg_in;
   logic [CSR_IDX_W-1:0]   idx;
   logic                   wr_en;

   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_CTRL1_X:      cfg_in.ctrl1_x      = csr_pwdata[CX_W-1:0];
            REG_CTRL1_Y:      cfg_in.ctrl1_y      = csr_pwdata[CY_W-1:0];
            REG_CTRL2_X:      cfg_in.ctrl2_x      = csr_pwdata[CX_W-1:0];
            REG_CTRL2_Y:      cfg_in.ctrl2_y      = csr_pwdata[CY_W-1:0];
            REG_REVERSE:      cfg_in.reverse      = csr_pwdata[0];
            REG_BISECT_STEPS: cfg_in.bisect_steps = csr_pwdata[STEPS_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ctrl1_x      <= CTRL1_X_RST;
         cfg_ff.ctrl1_y      <= CTRL1_Y_RST;
         cfg_ff.ctrl2_x      <= CTRL2_X_RST;
         cfg_ff.ctrl2_y      <= CTRL2_Y_RST;
         cfg_ff.reverse      <= REVERSE_RST;
         cfg_ff.bisect_steps <= BISECT_STEPS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read mux
   always_comb begin
      unique case (idx)
         REG_CTRL1_X:      csr_prdata = CSR_DATA_W'(cfg_ff.ctrl1_x);
         REG_CTRL1_Y:      csr_prdata = CSR_DATA_W'(cfg_ff.ctrl1_y);
         REG_CTRL2_X:      csr_prdata = CSR_DATA_W'(cfg_ff.ctrl2_x);
         REG_CTRL2_Y:      csr_prdata = CSR_DATA_W'(cfg_ff.ctrl2_y);
         REG_REVERSE:      csr_prdata = CSR_DATA_W'(cfg_ff.reverse);
         REG_BISECT_STEPS: csr_prdata = CSR_DATA_W'(cfg_ff.bisect_steps);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

[design/cbe_ctrl.sv]
// cbe_ctrl: sequencer for the bisection loop, the final y pass and the
// result handshake; depends on cbe_pkg
`default_nettype none

module cbe_ctrl #(
   parameter int MAX_STEPS = cbe_pkg::MAX_STEPS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic [cbe_pkg::STEPS_W-1:0]   bisect_steps,
   output cbe_pkg::cbe_cmd_type               cmd
);
   import cbe_pkg::*;

   localparam int CNT_W = $clog2(MAX_STEPS + 1);
   localparam int CMP_W = (CNT_W > STEPS_W) ? CNT_W + 1 : STEPS_W + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_MUL3 = 3'd3;
   localparam logic [2:0] ST_CMP  = 3'd4;
   localparam logic [2:0] ST_YSUM = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             ypass_ff, ypass_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] n_steps;

   // step count clamped to the supported maximum
   always_comb begin
      if (CMP_W'(bisect_steps) > CMP_W'(MAX_STEPS))
         n_steps = CNT_W'(MAX_STEPS);
      else
         n_steps = CNT_W'(bisect_steps);
   end

   // commands to the datapath
   always_comb begin
      cmd          = '0;
      cmd.start    = (state_ff == ST_IDLE) && req_tvalid;
      cmd.start_nz = (n_steps != '0);
      cmd.ypass    = ypass_ff;
      cmd.mul1     = (state_ff == ST_MUL1);
      cmd.mul2     = (state_ff == ST_MUL2);
      cmd.mul3     = (state_ff == ST_MUL3);
      cmd.cmp      = (state_ff == ST_CMP);
      cmd.last     = (rem_ff == CNT_W'(1));
      cmd.ysum     = (state_ff == ST_YSUM);
      cmd.out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      ypass_in = ypass_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MUL1;
               rem_in   = n_steps;
               ypass_in = (n_steps == '0);
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_MUL3;
         ST_MUL3: state_in = ypass_ff ? ST_YSUM : ST_CMP;
         ST_CMP: begin
            rem_in = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) begin
               // weights of the last midpoint are still held
               ypass_in = 1'b1;
               state_in = ST_MUL3;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_YSUM: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rem_ff       <= '0;
         ypass_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         ypass_ff     <= ypass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[design/cbe_dp.sv]
// cbe_dp: fixed-point datapath with three shared multipliers, the x compare,
// the y accumulator, mirror and saturation; depends on cbe_pkg
`default_nettype none

module cbe_dp (
   input  wire logic                          clock,
   input  wire logic [cbe_pkg::TIME_W-1:0]    time_in,
   input  wire cbe_pkg::cbe_cfg_type          cfg,
   input  wire cbe_pkg::cbe_cmd_type          cmd,
   output logic      [cbe_pkg::VAL_W-1:0]     value
);
   import cbe_pkg::*;

   localparam logic signed [TM_W-1:0]  ONE_TM  = TM_W'(1) << FRAC_BITS;
   localparam logic signed [V_W:0]     ONE_V   = (V_W+1)'(1) << FRAC_BITS;
   localparam logic [T_W:0]            T_ONE   = (T_W+1)'(1) << T_W;
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (T_W - 1);

   logic signed [TM_W-1:0]   tm_ff, tm_in;
   logic [T_W-1:0]           t_ff, t_in, d_ff, d_in;
   logic [T_W-2:0]           ut_ff;
   logic [T_W-1:0]           tt_ff;
   logic [T_W-1:0]           w1_ff, w2_ff, w3_ff;
   logic signed [PROD_W-1:0] p1_ff, p2_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [VAL_W-1:0]         value_ff;

   logic [T_W:0]             u;
   logic signed [MUL_W-1:0]  ma_a, ma_b, mb_a, mb_b, mc_a, mc_b;
   logic signed [2*MUL_W-1:0] pa, pb, pc;
   logic signed [CY_W-1:0]   coef1, coef2;
   logic [T_W-2:0]           q1, q2;
   logic signed [ACC_W-1:0]  p1_x, p2_x, p3_x, sum_c, tgt_x;
   logic                     gt;
   logic signed [V_W-1:0]    v;
   logic signed [V_W:0]      rv;
   logic [VAL_W-1:0]         sat_v;

   assign u = T_ONE - {1'b0, t_ff};

   // control point per term, x during the search and y for the result
   always_comb begin
      if (cmd.ypass) begin
         coef1 = $signed(cfg.ctrl1_y);
         coef2 = $signed(cfg.ctrl2_y);
      end else begin
         coef1 = $signed(CY_W'(cfg.ctrl1_x));
         coef2 = $signed(CY_W'(cfg.ctrl2_x));
      end
   end

   // multiplier operand selection
   always_comb begin
      ma_a = '0;
      ma_b = '0;
      mb_a = '0;
      mb_b = '0;
      mc_a = '0;
      mc_b = '0;
      if (cmd.mul1) begin
         ma_a = MUL_W'(u);
         ma_b = MUL_W'(t_ff);
         mb_a = MUL_W'(t_ff);
         mb_b = MUL_W'(t_ff);
      end else if (cmd.mul2) begin
         ma_a = MUL_W'(ut_ff);
         ma_b = MUL_W'(u);
         mb_a = MUL_W'(ut_ff);
         mb_b = MUL_W'(t_ff);
         mc_a = MUL_W'(tt_ff);
         mc_b = MUL_W'(t_ff);
      end else if (cmd.mul3) begin
         ma_a = MUL_W'(w1_ff);
         ma_b = MUL_W'(coef1);
         mb_a = MUL_W'(w2_ff);
         mb_b = MUL_W'(coef2);
      end
   end

   assign pa = ma_a * ma_b;
   assign pb = mb_a * mb_b;
   assign pc = mc_a * mc_b;

   // Q32 truncation of the weight products
   assign q1 = pa[T_W +: T_W-1];
   assign q2 = pb[T_W +: T_W-1];

   // x(t) or y(t) sum; rounding half added only for y
   assign p1_x  = ACC_W'(p1_ff);
   assign p2_x  = ACC_W'(p2_ff);
   assign p3_x  = ACC_W'({w3_ff, {FRAC_BITS{1'b0}}});
   assign sum_c = p1_x + p2_x + p3_x + (cmd.ypass ? RND_HALF : '0);
   assign tgt_x = ACC_W'($signed({tm_ff, {T_W{1'b0}}}));
   assign gt    = (tgt_x > sum_c);

   // time load and bisection update
   always_comb begin
      tm_in = tm_ff;
      t_in  = t_ff;
      d_in  = d_ff;
      if (cmd.start) begin
         if (cfg.reverse)
            tm_in = ONE_TM - TM_W'(time_in);
         else
            tm_in = TM_W'(time_in);
         t_in = cmd.start_nz ? (T_W'(1) << (T_W - 1)) : '0;
         d_in = T_W'(1) << (T_W - 2);
      end else if (cmd.cmp && !cmd.last) begin
         t_in = gt ? (t_ff + d_ff) : (t_ff - d_ff);
         d_in = d_ff >> 1;
      end
   end

   // round by arithmetic shift, mirror, saturate
   assign v  = acc_ff[ACC_W-1:T_W];
   assign rv = cfg.reverse ? (ONE_V - (V_W+1)'(v)) : (V_W+1)'(v);

   always_comb begin
      if (rv < OUT_MIN)
         sat_v = OUT_MIN[VAL_W-1:0];
      else if (rv > OUT_MAX)
         sat_v = OUT_MAX[VAL_W-1:0];
      else
         sat_v = rv[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      tm_ff <= tm_in;
      t_ff  <= t_in;
      d_ff  <= d_in;
      if (cmd.mul1) begin
         ut_ff <= q1;
         tt_ff <= pb[T_W +: T_W];
      end
      if (cmd.mul2) begin
         w1_ff <= {1'b0, q1} + {q1, 1'b0};
         w2_ff <= {1'b0, q2} + {q2, 1'b0};
         w3_ff <= pc[T_W +: T_W];
      end
      if (cmd.mul3) begin
         p1_ff <= pa[PROD_W-1:0];
         p2_ff <= pb[PROD_W-1:0];
      end
      if (cmd.ysum)
         acc_ff <= sum_c;
      if (cmd.out_load)
         value_ff <= sat_v;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

[design/cubic_bezier_easing.sv]
// cubic_bezier_easing: an accepted request runs n bisection steps, n = bisect_steps
// clamped to MAX_STEPS, then a y pass ending in ysum, and done loads the result
// one transaction at a time, no new request until the result is loaded: each bisection
// step passes mul1, mul2 and mul3 through the three shared multipliers, then the compare
// reset loads the register defaults and empties the result register; no clearing pass
`default_nettype none

module cubic_bezier_easing #(
   parameter int MAX_STEPS = cbe_pkg::MAX_STEPS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [cbe_pkg::REQ_DATA_W-1:0]    req_tdata,   // [16:0] time_in
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [cbe_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [18:0] value
   // configuration port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cbe_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [cbe_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [cbe_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);
   import cbe_pkg::*;

   cbe_cfg_type      cfg;
   cbe_cmd_type      cmd;
   logic [VAL_W-1:0] value;

   cbe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cbe_ctrl #(
      .MAX_STEPS (MAX_STEPS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .bisect_steps (cfg.bisect_steps),
      .cmd          (cmd)
   );

   cbe_dp u_dp (
      .clock   (clock),
      .time_in (req_tdata[TIME_W-1:0]),
      .cfg     (cfg),
      .cmd     (cmd),
      .value   (value)
   );

   assign rsp_tdata = RSP_DATA_W'(value);

`ifndef SYNTHESIS
   // the block is busy right after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a transaction is in flight");

   // a result appears exactly when the sequencer returns to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result raised outside the end of a transaction");

   // the result register is only loaded into a free slot
   a_load_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten before it was taken");
`endif

endmodule

`default_nettype wire
